>>> src/saps_pkg.sv
package saps_pkg;

    localparam int SAPS_POSITION_BITS   = 24;
    localparam int SAPS_HALF_STEPS_TURN = 4096;

    localparam int SAPS_ANGLE_BITS = 17;
    localparam int SAPS_GEAR_BITS  = 16;
    localparam int SAPS_ADDR_BITS  = 4;
    localparam int SAPS_DATA_BITS  = 32;

    // centidegrees per revolution times the Q8.8 scale
    localparam int SAPS_ANGLE_DIVISOR = 256 * 36000;
    // step target is (angle * gear + SAPS_ROUND_BIAS) / SAPS_STEP_DIVISOR
    localparam int SAPS_STEP_DIVISOR  = SAPS_ANGLE_DIVISOR / SAPS_HALF_STEPS_TURN;
    localparam int SAPS_ROUND_BIAS    = SAPS_STEP_DIVISOR / 2;
    // reciprocal of the step divisor, exact for dividends below 2^32
    localparam int     SAPS_RECIP_SHIFT = 44;
    localparam longint SAPS_RECIP       = ((longint'(1) << SAPS_RECIP_SHIFT)
                                           + longint'(SAPS_STEP_DIVISOR) - 1)
                                          / longint'(SAPS_STEP_DIVISOR);
    localparam int     SAPS_RECIP_BITS  = $clog2(SAPS_RECIP + 1);
    localparam int     SAPS_MIN_DELTA   = 10;

    localparam logic [SAPS_ANGLE_BITS-1:0] SAPS_ANGLE_LOW_RST  = 17'sd0;
    localparam logic [SAPS_ANGLE_BITS-1:0] SAPS_ANGLE_HIGH_RST = 17'sd36000;
    localparam logic [SAPS_GEAR_BITS-1:0]  SAPS_GEAR_RST       = 16'd256;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_HOME   = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_HOME = 2'd2;

    localparam logic [1:0] REG_ANGLE_LOW  = 2'd0;
    localparam logic [1:0] REG_ANGLE_HIGH = 2'd1;
    localparam logic [1:0] REG_GEAR_RATIO = 2'd2;

    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pattern;
        unique case (phase)
            3'd0: pattern = 4'h1;
            3'd1: pattern = 4'h3;
            3'd2: pattern = 4'h2;
            3'd3: pattern = 4'h6;
            3'd4: pattern = 4'h4;
            3'd5: pattern = 4'hC;
            3'd6: pattern = 4'h8;
            3'd7: pattern = 4'h9;
        endcase
        return pattern;
    endfunction

endpackage

>>> src/stepper_angle_position_sequencer.sv
// result: registered, valid in the cycle after the item transfer
// throughput: one item per cycle for ticks, homing and ignored targets while each result is taken
// a target that moves blocks new items while the step target is scaled in CV_MUL,
// CV_RECIP and CV_APPLY (gear product, reciprocal multiply, saturation and sign)
// reset: async active low, configuration registers to reset values, mode idle, no result pending
module stepper_angle_position_sequencer
    import saps_pkg::*;
#(
    parameter int POSITION_BITS = SAPS_POSITION_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [SAPS_ADDR_BITS-1:0]         paddr,
    input  logic [SAPS_DATA_BITS-1:0]         pwdata,
    output logic [SAPS_DATA_BITS-1:0]         prdata,
    output logic                              pready,

    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        operation,
    input  logic signed [SAPS_ANGLE_BITS-1:0] angle_cmd,
    input  logic                              limit_active,

    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [3:0]                        coils,
    output logic                              busy_res,
    output logic                              homing,
    output logic signed [POSITION_BITS-1:0]   position
);

    localparam int AW = SAPS_ANGLE_BITS;
    localparam int QW = POSITION_BITS - 1;
    localparam int PW = AW + SAPS_GEAR_BITS;
    // rounded product stays below 2^32 for any 17-bit angle and 16-bit gear
    localparam int SW = 32;
    localparam int MW = SW + SAPS_RECIP_BITS;
    localparam int FW = MW - SAPS_RECIP_SHIFT;
    localparam longint POS_MAX = (longint'(1) << QW) - 1;

    localparam logic [1:0] CV_IDLE  = 2'd0;
    localparam logic [1:0] CV_MUL   = 2'd1;
    localparam logic [1:0] CV_RECIP = 2'd2;
    localparam logic [1:0] CV_APPLY = 2'd3;

    // configuration
    logic signed [AW-1:0]         angle_low_reg;
    logic signed [AW-1:0]         angle_high_reg;
    logic [SAPS_GEAR_BITS-1:0]    gear_ratio_reg;
    logic                         cfg_write;

    // motor state
    logic signed [POSITION_BITS-1:0] step_position_reg, step_position_next;
    logic signed [POSITION_BITS-1:0] step_target_reg, step_target_next;
    logic signed [AW-1:0]            last_angle_reg, last_angle_next;
    logic                            last_valid_reg, last_valid_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [1:0]                      mode_reg, mode_next;

    // result register
    logic                            result_valid_reg;
    logic [3:0]                      coils_reg, coils_next;
    logic                            busy_reg;
    logic                            homing_reg;
    logic signed [POSITION_BITS-1:0] position_reg;

    // target scaling unit
    logic [1:0]      cv_state_reg, cv_state_next;
    logic [AW-1:0]   mag_reg, mag_next;
    logic            neg_reg, neg_next;
    logic [SW-1:0]   sum_reg;
    logic [FW-1:0]   quo_reg;

    logic                 accept;
    logic                 start_cv;
    logic                 cv_done;
    logic signed [AW-1:0] clamped;
    logic signed [AW:0]   delta;
    logic [AW:0]          delta_abs;
    logic                 take_target;
    logic [PW-1:0]        prod;
    logic [MW-1:0]        recip_prod;
    logic                 quo_sat;
    logic [POSITION_BITS-1:0] target_mag;
    logic [2:0]           phase_up;
    logic [2:0]           phase_dn;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ANGLE_LOW:  prdata = SAPS_DATA_BITS'(angle_low_reg);
            REG_ANGLE_HIGH: prdata = SAPS_DATA_BITS'(angle_high_reg);
            REG_GEAR_RATIO: prdata = SAPS_DATA_BITS'(gear_ratio_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_low_reg  <= SAPS_ANGLE_LOW_RST;
            angle_high_reg <= SAPS_ANGLE_HIGH_RST;
            gear_ratio_reg <= SAPS_GEAR_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ANGLE_LOW:  angle_low_reg  <= pwdata[AW-1:0];
                REG_ANGLE_HIGH: angle_high_reg <= pwdata[AW-1:0];
                REG_GEAR_RATIO: gear_ratio_reg <= pwdata[SAPS_GEAR_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign item_ready = (cv_state_reg == CV_IDLE) && (!result_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    // clamp and minimum-change filter for a new target
    always_comb
    begin
        priority if (angle_cmd < angle_low_reg)
            clamped = angle_low_reg;
        else if (angle_cmd > angle_high_reg)
            clamped = angle_high_reg;
        else
            clamped = angle_cmd;
    end

    assign delta       = {clamped[AW-1], clamped} - {last_angle_reg[AW-1], last_angle_reg};
    assign delta_abs   = delta[AW] ? (AW+1)'(-delta) : delta;
    assign take_target = !(last_valid_reg && (delta_abs < (AW+1)'(SAPS_MIN_DELTA)));

    assign phase_up = phase_reg + 3'd1;
    assign phase_dn = phase_reg - 3'd1;

    // scaling datapath: round half away from zero of |angle| * gear / divisor,
    // the division done by a reciprocal multiply
    assign prod       = PW'(mag_reg) * PW'(gear_ratio_reg);
    assign recip_prod = MW'(sum_reg) * MW'(SAPS_RECIP);
    assign quo_sat    = longint'(quo_reg) > POS_MAX;
    assign target_mag = quo_sat ? POSITION_BITS'(POS_MAX) : POSITION_BITS'(quo_reg);
    assign cv_done    = (cv_state_reg == CV_APPLY);

    always_comb
    begin
        step_position_next = step_position_reg;
        step_target_next   = step_target_reg;
        last_angle_next    = last_angle_reg;
        last_valid_next    = last_valid_reg;
        phase_next         = phase_reg;
        mode_next          = mode_reg;
        coils_next         = 4'h0;
        start_cv           = 1'b0;
        mag_next           = mag_reg;
        neg_next           = neg_reg;

        if (accept)
        begin
            unique case (operation)
                OP_TICK:
                begin
                    if (mode_reg == MODE_MOVE)
                    begin
                        priority if (step_position_reg == step_target_reg)
                            mode_next = MODE_IDLE;
                        else if (step_target_reg > step_position_reg)
                        begin
                            step_position_next = step_position_reg + 1'b1;
                            phase_next         = phase_up;
                            coils_next         = phase_coils(phase_up);
                        end
                        else
                        begin
                            step_position_next = step_position_reg - 1'b1;
                            phase_next         = phase_dn;
                            coils_next         = phase_coils(phase_dn);
                        end
                    end
                    else if (mode_reg == MODE_HOME)
                    begin
                        if (limit_active)
                        begin
                            step_position_next = step_position_reg - 1'b1;
                            phase_next         = phase_dn;
                            coils_next         = phase_coils(phase_dn);
                        end
                        else
                        begin
                            step_position_next = '0;
                            step_target_next   = '0;
                            last_angle_next    = '0;
                            last_valid_next    = 1'b1;
                            mode_next          = MODE_IDLE;
                        end
                    end
                end
                OP_TARGET:
                begin
                    if (mode_reg != MODE_HOME && take_target)
                    begin
                        last_angle_next = clamped;
                        last_valid_next = 1'b1;
                        mode_next       = MODE_MOVE;
                        start_cv        = 1'b1;
                        neg_next        = clamped[AW-1];
                        mag_next        = clamped[AW-1] ? AW'(-{clamped[AW-1], clamped})
                                                        : clamped;
                    end
                end
                OP_HOME:
                    mode_next = MODE_HOME;
                default:
                    ;
            endcase
        end
        else if (cv_done)
        begin
            step_target_next = neg_reg ? -target_mag : target_mag;
        end
    end

    always_comb
    begin
        cv_state_next = cv_state_reg;
        unique case (cv_state_reg)
            CV_IDLE:  if (start_cv) cv_state_next = CV_MUL;
            CV_MUL:   cv_state_next = CV_RECIP;
            CV_RECIP: cv_state_next = CV_APPLY;
            CV_APPLY: cv_state_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_position_reg <= '0;
            step_target_reg   <= '0;
            last_angle_reg    <= '0;
            last_valid_reg    <= 1'b0;
            phase_reg         <= 3'd0;
            mode_reg          <= MODE_IDLE;
            cv_state_reg      <= CV_IDLE;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            step_position_reg <= step_position_next;
            step_target_reg   <= step_target_next;
            last_angle_reg    <= last_angle_next;
            last_valid_reg    <= last_valid_next;
            phase_reg         <= phase_next;
            mode_reg          <= mode_next;
            cv_state_reg      <= cv_state_next;
            if (accept)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coils_reg    <= coils_next;
            busy_reg     <= (mode_next != MODE_IDLE);
            homing_reg   <= (mode_next == MODE_HOME);
            position_reg <= step_position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        if (cv_state_reg == CV_MUL)
            sum_reg <= SW'(prod) + SW'(SAPS_ROUND_BIAS);
        if (cv_state_reg == CV_RECIP)
            quo_reg <= recip_prod[MW-1:SAPS_RECIP_SHIFT];
    end

    assign result_valid = result_valid_reg;
    assign coils        = coils_reg;
    assign busy_res     = busy_reg;
    assign homing       = homing_reg;
    assign position     = position_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import saps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PERCENT = 35;
    localparam int HOLD_AFTER_ITEMS = 110;
    localparam int MAX_PRINTED = 100;
    localparam longint POS_MAX = (longint'(1) << (SAPS_POSITION_BITS - 1)) - 1;
    localparam logic [1:0] OP_NONE = 2'd3;
    // half-step coil patterns, phase 0 in the low nibble
    localparam logic [31:0] COIL_SEQUENCE = 32'h98C4_6231;

    typedef struct packed {
        logic [1:0]                 op;
        logic [SAPS_ANGLE_BITS-1:0] angle;
        logic                       lim;
    } motor_cmd_t;

    typedef struct packed {
        logic [3:0]                    coils;
        logic                          busy;
        logic                          homing;
        logic [SAPS_POSITION_BITS-1:0] position;
    } motor_out_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [SAPS_ADDR_BITS-1:0]          paddr = '0;
    logic [SAPS_DATA_BITS-1:0]          pwdata = '0;
    logic [SAPS_DATA_BITS-1:0]          prdata;
    logic                               pready;
    logic                               item_valid = 1'b0;
    logic                               item_ready;
    logic [1:0]                         operation = OP_TICK;
    logic signed [SAPS_ANGLE_BITS-1:0]  angle_cmd = '0;
    logic                               limit_active = 1'b0;
    logic                               result_valid;
    logic                               result_ready = 1'b0;
    logic [3:0]                         coils;
    logic                               busy_res;
    logic                               homing;
    logic signed [SAPS_POSITION_BITS-1:0] position;

    // sequencer state as predicted
    logic signed [SAPS_POSITION_BITS-1:0] half_step_pos = '0;
    logic signed [SAPS_POSITION_BITS-1:0] half_step_goal = '0;
    logic signed [SAPS_ANGLE_BITS-1:0]    accepted_angle = '0;
    logic                                 accepted_angle_valid = 1'b0;
    logic [2:0]                           coil_phase = '0;
    logic [1:0]                           motor_mode = MODE_IDLE;
    logic signed [SAPS_ANGLE_BITS-1:0]    window_low = SAPS_ANGLE_LOW_RST;
    logic signed [SAPS_ANGLE_BITS-1:0]    window_high = SAPS_ANGLE_HIGH_RST;
    logic [SAPS_GEAR_BITS-1:0]            gear_q88 = SAPS_GEAR_RST;

    motor_cmd_t pending_cmds[$];
    motor_out_t expected_outputs[$];
    logic       cmd_outstanding = 1'b0;
    logic       hold_results = 1'b0;
    int         accepted_count = 0;
    int         planned_count = 0;
    int         last_planned_angle = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    wire steady_stretch = (cycle_count >= 1500) && (cycle_count < 2500);

    stepper_angle_position_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .angle_cmd    (angle_cmd),
        .limit_active (limit_active),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .coils        (coils),
        .busy_res     (busy_res),
        .homing       (homing),
        .position     (position)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** stepper_angle_position_sequencer: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic advance_sequencer(input logic [1:0] op,
                                     input logic signed [SAPS_ANGLE_BITS-1:0] angle,
                                     input logic lim);
        motor_out_t                        outp;
        logic signed [SAPS_ANGLE_BITS-1:0] clamped;
        int                                gap;
        longint                            magnitude;
        longint                            steps;
        outp.coils = 4'h0;
        case (op)
            OP_TICK:
                if (motor_mode == MODE_MOVE)
                begin
                    if (half_step_pos == half_step_goal)
                        motor_mode = MODE_IDLE;
                    else if (half_step_goal > half_step_pos)
                    begin
                        half_step_pos = half_step_pos + 1'b1;
                        coil_phase = coil_phase + 3'd1;
                        outp.coils = COIL_SEQUENCE[4*coil_phase +: 4];
                    end
                    else
                    begin
                        half_step_pos = half_step_pos - 1'b1;
                        coil_phase = coil_phase - 3'd1;
                        outp.coils = COIL_SEQUENCE[4*coil_phase +: 4];
                    end
                end
                else if (motor_mode == MODE_HOME)
                begin
                    if (lim)
                    begin
                        half_step_pos = half_step_pos - 1'b1;
                        coil_phase = coil_phase - 3'd1;
                        outp.coils = COIL_SEQUENCE[4*coil_phase +: 4];
                    end
                    else
                    begin
                        half_step_pos = '0;
                        half_step_goal = '0;
                        accepted_angle = '0;
                        accepted_angle_valid = 1'b1;
                        motor_mode = MODE_IDLE;
                    end
                end
            OP_TARGET:
                if (motor_mode != MODE_HOME)
                begin
                    // low bound is tested first, which matters for an inverted window
                    if (angle < window_low)
                        clamped = window_low;
                    else if (angle > window_high)
                        clamped = window_high;
                    else
                        clamped = angle;
                    gap = int'(clamped) - int'(accepted_angle);
                    if (gap < 0)
                        gap = -gap;
                    if (!(accepted_angle_valid && gap < SAPS_MIN_DELTA))
                    begin
                        // round half away from zero, saturate to the position range
                        magnitude = (clamped < 0) ? -longint'(clamped) : longint'(clamped);
                        steps = (magnitude * longint'(gear_q88) * SAPS_HALF_STEPS_TURN
                                 + SAPS_ANGLE_DIVISOR / 2) / SAPS_ANGLE_DIVISOR;
                        if (steps > POS_MAX)
                            steps = POS_MAX;
                        half_step_goal = SAPS_POSITION_BITS'((clamped < 0) ? -steps : steps);
                        accepted_angle = clamped;
                        accepted_angle_valid = 1'b1;
                        motor_mode = MODE_MOVE;
                    end
                end
            OP_HOME:
                motor_mode = MODE_HOME;
            default:
                ;
        endcase
        outp.busy = (motor_mode != MODE_IDLE);
        outp.homing = (motor_mode == MODE_HOME);
        outp.position = half_step_pos;
        expected_outputs.push_back(outp);
    endtask

    // item driver
    always @(posedge clk)
    begin : item_driver
        motor_cmd_t next_cmd;
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
            begin
                advance_sequencer(operation, angle_cmd, limit_active);
                accepted_count++;
                cmd_outstanding = 1'b0;
            end
            if (!cmd_outstanding)
            begin
                if (pending_cmds.size() != 0
                    && (steady_stretch || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    next_cmd = pending_cmds.pop_front();
                    item_valid <= 1'b1;
                    operation <= next_cmd.op;
                    angle_cmd <= next_cmd.angle;
                    limit_active <= next_cmd.lim;
                    cmd_outstanding = 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_results
                            && (steady_stretch || $urandom_range(99) >= IDLE_PERCENT);
    end

    // long receiver stall so the block backs up into its input
    initial
    begin : result_hold
        int held;
        wait (accepted_count >= HOLD_AFTER_ITEMS);
        @(posedge clk);
        hold_results <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge clk);
        hold_results <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        motor_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch($sformatf("result transfer with nothing expected, coils %h position %0d",
                                          coils, position));
            else
            begin
                want = expected_outputs.pop_front();
                if (coils !== want.coils)
                    report_mismatch($sformatf("coils %h, expected %h", coils, want.coils));
                if (busy_res !== want.busy)
                    report_mismatch($sformatf("busy_res %b, expected %b", busy_res, want.busy));
                if (homing !== want.homing)
                    report_mismatch($sformatf("homing %b, expected %b", homing, want.homing));
                if (position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              position, $signed(want.position)));
            end
        end
    end

    task automatic write_register(input logic [1:0] index, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_ANGLE_LOW:  window_low = value[SAPS_ANGLE_BITS-1:0];
            REG_ANGLE_HIGH: window_high = value[SAPS_ANGLE_BITS-1:0];
            REG_GEAR_RATIO: gear_q88 = value[SAPS_GEAR_BITS-1:0];
            default:        ;
        endcase
    endtask

    task automatic apply_settings(input int low_cd, input int high_cd, input int ratio);
        write_register(REG_ANGLE_LOW, low_cd);
        write_register(REG_ANGLE_HIGH, high_cd);
        write_register(REG_GEAR_RATIO, ratio);
    endtask

    task automatic wait_until_drained();
        @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_outstanding || expected_outputs.size() != 0)
            @(posedge clk);
        // a moving target keeps the block scaling for a while after its result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_cmd(input logic [1:0] op, input int angle, input logic lim);
        motor_cmd_t c;
        c.op = op;
        c.angle = angle[SAPS_ANGLE_BITS-1:0];
        c.lim = lim;
        pending_cmds.push_back(c);
        planned_count++;
        if (op == OP_TARGET)
            last_planned_angle = angle;
    endtask

    function automatic int any_angle();
        return int'($urandom_range(72000)) - 36000;
    endfunction

    task automatic plan_random_phase(input int n_items);
        int goal;
        int roll;
        int count;
        int angle;
        goal = planned_count + n_items;
        while (planned_count < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                // move: a target then a run of ticks toward it
                queue_cmd(OP_TARGET, any_angle(), 1'($urandom_range(1)));
                count = $urandom_range(1, 24);
                repeat (count) queue_cmd(OP_TICK, any_angle(), 1'($urandom_range(1)));
            end
            else if (roll < 60)
            begin
                // small adjustment around the minimum change
                angle = last_planned_angle + int'($urandom_range(30)) - 15;
                if (angle > 36000)
                    angle = 36000;
                if (angle < -36000)
                    angle = -36000;
                queue_cmd(OP_TARGET, angle, 1'($urandom_range(1)));
                count = $urandom_range(0, 4);
                repeat (count) queue_cmd(OP_TICK, any_angle(), 1'($urandom_range(1)));
            end
            else if (roll < 75)
            begin
                queue_cmd(OP_HOME, any_angle(), 1'($urandom_range(1)));
                count = $urandom_range(0, 6);
                repeat (count) queue_cmd(OP_TICK, any_angle(), 1'b1);
                if ($urandom_range(3) == 0)
                    queue_cmd(OP_TARGET, any_angle(), 1'($urandom_range(1)));
                queue_cmd(OP_TICK, any_angle(), 1'b0);
            end
            else if (roll < 92)
                queue_cmd(OP_TICK, any_angle(), 1'($urandom_range(1)));
            else if (roll < 96)
                queue_cmd(OP_NONE, any_angle(), 1'($urandom_range(1)));
            else
            begin
                // homing left running into whatever comes next
                queue_cmd(OP_HOME, any_angle(), 1'($urandom_range(1)));
                queue_cmd(OP_TICK, any_angle(), 1'b1);
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int low_cd;
        int high_cd;
        int ratio;
        int roll;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // settings after reset: window 0 to 36000, one to one gear
        queue_cmd(OP_TICK, 0, 1'b0);
        queue_cmd(OP_NONE, -36000, 1'b1);
        queue_cmd(OP_TARGET, 0, 1'b0);      // first target moves even onto the position
        queue_cmd(OP_TICK, 0, 1'b0);
        queue_cmd(OP_TARGET, 5, 1'b0);      // under the minimum change
        queue_cmd(OP_TARGET, -36000, 1'b0); // clamps to zero, under the minimum change
        queue_cmd(OP_TARGET, 36000, 1'b0);
        queue_cmd(OP_TICK, 65535, 1'b1);
        queue_cmd(OP_TICK, -65536, 1'b0);
        queue_cmd(OP_HOME, 0, 1'b1);        // abandons the move
        queue_cmd(OP_TARGET, 100, 1'b1);    // dropped while homing
        queue_cmd(OP_TICK, 0, 1'b1);
        queue_cmd(OP_TICK, 0, 1'b1);
        queue_cmd(OP_TICK, 0, 1'b0);
        queue_cmd(OP_TARGET, 9, 1'b0);
        queue_cmd(OP_TARGET, 10, 1'b0);
        queue_cmd(OP_TICK, 0, 1'b0);
        wait_until_drained();

        apply_settings(-36000, 36000, 1);
        queue_cmd(OP_TARGET, -36000, 1'b0);
        queue_cmd(OP_TICK, 0, 1'b0);
        queue_cmd(OP_TARGET, 1125, 1'b0);   // exactly half a step, rounds away from zero
        queue_cmd(OP_TARGET, -1125, 1'b0);
        wait_until_drained();

        // inverted window
        apply_settings(100, -100, 65535);
        queue_cmd(OP_TARGET, 50, 1'b0);
        queue_cmd(OP_TICK, 0, 1'b0);
        queue_cmd(OP_TARGET, -50, 1'b0);
        queue_cmd(OP_TARGET, 36000, 1'b0);
        wait_until_drained();

        // zero gear sends every target to step zero
        apply_settings(-36000, 36000, 0);
        queue_cmd(OP_TARGET, 20000, 1'b0);
        queue_cmd(OP_TICK, 0, 1'b0);
        wait_until_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            low_cd = -int'($urandom_range(36000));
            high_cd = int'($urandom_range(36000));
            if ($urandom_range(99) < 12)
            begin
                roll = low_cd;
                low_cd = high_cd;
                high_cd = roll;
            end
            roll = $urandom_range(99);
            if (roll < 70)
                ratio = $urandom_range(1, 16);
            else if (roll < 90)
                ratio = $urandom_range(17, 512);
            else if (roll < 95)
                ratio = 0;
            else
                ratio = $urandom_range(513, 65535);
            if (phase == 0)
            begin
                low_cd = -36000;
                high_cd = 36000;
                ratio = 65535;
            end
            else if (phase == 4)
            begin
                low_cd = -36000;
                high_cd = -36000;
                ratio = 1;
            end
            else if (phase == 7)
            begin
                low_cd = 36000;
                high_cd = 36000;
                ratio = $urandom_range(1, 16);
            end
            apply_settings(low_cd, high_cd, ratio);
            plan_random_phase(54);
            wait_until_drained();
        end

        if (error_count == 0)
            $display("** stepper_angle_position_sequencer: PASSED **");
        else
            $display("** stepper_angle_position_sequencer: FAILED **");
        $finish;
    end

endmodule
